// ----- src/two_axis_pid_tracker_core_macros.svh -----
// assertion macros for the pan/tilt tracker checker
// expects clk and arst_n in the scope where a macro is used
`ifndef TWO_AXIS_PID_TRACKER_CORE_MACROS_SVH
`define TWO_AXIS_PID_TRACKER_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define TPT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tpt_pkg.sv -----
// shared types, step codes and constants of the pan/tilt tracker
// no dependencies
`default_nettype none
package tpt_pkg;

	// register indexes on the apb port
	localparam logic [2:0] REG_PROP   = 3'd0;
	localparam logic [2:0] REG_INTEG  = 3'd1;
	localparam logic [2:0] REG_DERIV  = 3'd2;
	localparam logic [2:0] REG_DEAD   = 3'd3;
	localparam logic [2:0] REG_ALPHA  = 3'd4;
	localparam logic [2:0] REG_QNOISE = 3'd5;
	localparam logic [2:0] REG_RNOISE = 3'd6;
	localparam logic [2:0] REG_KEN    = 3'd7;

	// sequencer steps, also the datapath command code
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_LOAD = 5'd1;
	localparam logic [4:0] ST_DIVI = 5'd2;
	localparam logic [4:0] ST_DIVS = 5'd3;
	localparam logic [4:0] ST_MKD  = 5'd4;
	localparam logic [4:0] ST_EST  = 5'd5;
	localparam logic [4:0] ST_MCOV = 5'd6;
	localparam logic [4:0] ST_COV  = 5'd7;
	localparam logic [4:0] ST_DEAD = 5'd8;
	localparam logic [4:0] ST_MP   = 5'd9;
	localparam logic [4:0] ST_MI   = 5'd10;
	localparam logic [4:0] ST_MD   = 5'd11;
	localparam logic [4:0] ST_ACC1 = 5'd12;
	localparam logic [4:0] ST_CLO  = 5'd13;
	localparam logic [4:0] ST_MA   = 5'd14;
	localparam logic [4:0] ST_MNA  = 5'd15;
	localparam logic [4:0] ST_ACC2 = 5'd16;
	localparam logic [4:0] ST_LPU  = 5'd17;
	localparam logic [4:0] ST_ANG  = 5'd18;
	localparam logic [4:0] ST_OUT  = 5'd19;

	localparam logic [4:0] DIV_LAST = 5'd23;

	localparam logic [24:0] ONE_Q24 = 25'h100_0000;
	localparam logic [31:0] COV_RESET = 32'h0100_0000;
	localparam logic [23:0] PAN_RESET = 24'd5898240;
	localparam logic [22:0] TILT_RESET = 23'd5242880;
	localparam logic signed [33:0] INTEG_LIM = 34'sd65536000;
	localparam logic signed [33:0] PAN_MIN = 34'sd1310720;
	localparam logic signed [33:0] PAN_MAX = 34'sd10485760;
	localparam logic signed [33:0] TILT_MIN = 34'sd2621440;
	localparam logic signed [33:0] TILT_MAX = 34'sd6553600;
	localparam logic signed [11:0] CENTRE_PX = 12'sd320;

	typedef struct packed {
		logic [30:0] prop_gain;
		logic [30:0] integ_gain;
		logic [30:0] deriv_gain;
		logic [30:0] dead_zone;
		logic [24:0] smoothing_alpha;
		logic [30:0] process_noise;
		logic [30:0] measure_noise;
		logic        kalman_enable;
	} cfg_t;

	typedef struct packed {
		logic [4:0] op;
		logic       axis;
		logic       load_in;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic dead_hit;
	} sts_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi)
			sat32 = 32'sh7FFF_FFFF;
		else if (v < lo)
			sat32 = 32'sh8000_0000;
		else
			sat32 = v[31:0];
	endfunction

	// clamp a signed value into a range
	function automatic logic signed [33:0] clamp34(input logic signed [33:0] v,
		input logic signed [33:0] lo, input logic signed [33:0] hi);
		if (v < lo)
			clamp34 = lo;
		else if (v > hi)
			clamp34 = hi;
		else
			clamp34 = v;
	endfunction

endpackage
`default_nettype wire

// ----- src/tpt_regs.sv -----
// apb configuration registers of the pan/tilt tracker
// depends on tpt_pkg
`default_nettype none
module tpt_regs import tpt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output cfg_t             cfg
);
	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= 31'd41943;
			cfg_q.integ_gain      <= 31'd0;
			cfg_q.deriv_gain      <= 31'd50332;
			cfg_q.dead_zone       <= 31'd6553600;
			cfg_q.smoothing_alpha <= 25'd8388608;
			cfg_q.process_noise   <= 31'd838861;
			cfg_q.measure_noise   <= 31'd16777216;
			cfg_q.kalman_enable   <= 1'b0;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_PROP:   cfg_q.prop_gain       <= pwdata[30:0];
				REG_INTEG:  cfg_q.integ_gain      <= pwdata[30:0];
				REG_DERIV:  cfg_q.deriv_gain      <= pwdata[30:0];
				REG_DEAD:   cfg_q.dead_zone       <= pwdata[30:0];
				REG_ALPHA:  cfg_q.smoothing_alpha <= pwdata[24:0];
				REG_QNOISE: cfg_q.process_noise   <= pwdata[30:0];
				REG_RNOISE: cfg_q.measure_noise   <= pwdata[30:0];
				REG_KEN:    cfg_q.kalman_enable   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[4:2])
			REG_PROP:   prdata = {1'b0, cfg_q.prop_gain};
			REG_INTEG:  prdata = {1'b0, cfg_q.integ_gain};
			REG_DERIV:  prdata = {1'b0, cfg_q.deriv_gain};
			REG_DEAD:   prdata = {1'b0, cfg_q.dead_zone};
			REG_ALPHA:  prdata = {7'b0, cfg_q.smoothing_alpha};
			REG_QNOISE: prdata = {1'b0, cfg_q.process_noise};
			REG_RNOISE: prdata = {1'b0, cfg_q.measure_noise};
			REG_KEN:    prdata = {31'b0, cfg_q.kalman_enable};
			default:    prdata = 32'b0;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/tpt_ctrl.sv -----
// sequencer of the pan/tilt tracker: steps both axes through the shared datapath
// depends on tpt_pkg
`default_nettype none
module tpt_ctrl import tpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire logic kalman_en,
	input  sts_t      sts,
	output cmd_t      cmd
);
	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       axis_q;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | out_ready;

	assign cmd.op       = state_q;
	assign cmd.axis     = axis_q;
	assign cmd.load_in  = (state_q == ST_IDLE) & in_valid;
	assign cmd.load_out = (state_q == ST_OUT) & out_free;

	// next step
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_LOAD;
			ST_LOAD: state_d = kalman_en ? ST_DIVI : ST_DEAD;
			ST_DIVI: state_d = ST_DIVS;
			ST_DIVS: if (cnt_q == DIV_LAST) state_d = ST_MKD;
			ST_MKD:  state_d = ST_EST;
			ST_EST:  state_d = ST_MCOV;
			ST_MCOV: state_d = ST_COV;
			ST_COV:  state_d = ST_DEAD;
			ST_DEAD: state_d = sts.dead_hit ? ST_ANG : ST_MP;
			ST_MP:   state_d = ST_MI;
			ST_MI:   state_d = ST_MD;
			ST_MD:   state_d = ST_ACC1;
			ST_ACC1: state_d = ST_CLO;
			ST_CLO:  state_d = ST_MA;
			ST_MA:   state_d = ST_MNA;
			ST_MNA:  state_d = ST_ACC2;
			ST_ACC2: state_d = ST_LPU;
			ST_LPU:  state_d = ST_ANG;
			ST_ANG:  state_d = axis_q ? ST_OUT : ST_LOAD;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state, axis and divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
			cnt_q   <= 5'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				axis_q <= 1'b0;
			else if (state_q == ST_ANG)
				axis_q <= 1'b1;
			if (state_q == ST_DIVS)
				cnt_q <= cnt_q + 5'd1;
			else
				cnt_q <= 5'd0;
		end
	end

	// result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end
endmodule
`default_nettype wire

// ----- src/tpt_dp.sv -----
// datapath of the pan/tilt tracker: one shared multiplier, accumulator,
// bit-serial divider for the kalman gain and per-axis state; depends on tpt_pkg
`default_nettype none
module tpt_dp import tpt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cfg_t             cfg,
	input  cmd_t             cmd,
	input  wire logic [9:0]  target_x,
	input  wire logic [9:0]  target_y,
	output sts_t             sts,
	output logic      [23:0] pan_angle,
	output logic      [22:0] tilt_angle
);
	logic [9:0]  tx_q, ty_q;
	logic signed [31:0] e_q;
	logic [31:0] p_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [23:0] k_q;
	logic signed [65:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] integ_q;
	logic signed [32:0] deriv_q;
	logic signed [31:0] o_q;
	logic signed [31:0] delta_q;
	logic [23:0] pan_q;
	logic [22:0] tilt_q;
	logic [23:0] out_pan_q;
	logic [22:0] out_tilt_q;
	logic signed [31:0] est_q [2];
	logic [31:0] cov_q [2];
	logic signed [31:0] isum_q [2];
	logic signed [31:0] perr_q [2];
	logic signed [31:0] pout_q [2];

	logic [9:0]  tsel;
	logic signed [11:0] px;
	logic signed [31:0] e_load;
	logic [30:0] q_eff, r_eff;
	logic [32:0] psum;
	logic [31:0] p_new;
	logic [33:0] rem2;
	logic        div_ge;
	logic [24:0] a_lim, a_comp, k_comp;
	logic [31:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [66:0] mul_full;
	logic signed [65:0] est_sum;
	logic signed [32:0] e33, mag;
	logic signed [33:0] isum_new;
	logic signed [33:0] pan_new, tilt_new;
	logic signed [31:0] lp_f;

	assign pan_angle  = out_pan_q;
	assign tilt_angle = out_tilt_q;

	// error from centre in q16.16
	assign tsel   = cmd.axis ? ty_q : tx_q;
	assign px     = $signed({2'b0, tsel}) - CENTRE_PX;
	assign e_load = {{4{px[11]}}, px, 16'b0};

	// predicted covariance, saturating
	assign q_eff = (cfg.process_noise == 31'd0) ? 31'd1 : cfg.process_noise;
	assign r_eff = (cfg.measure_noise == 31'd0) ? 31'd1 : cfg.measure_noise;
	assign psum  = {1'b0, cov_q[cmd.axis]} + {2'b0, q_eff};
	assign p_new = psum[32] ? 32'hFFFF_FFFF : psum[31:0];

	// restoring divider step
	assign rem2   = {rem_q, 1'b0};
	assign div_ge = rem2 >= {1'b0, den_q};

	assign a_lim  = (cfg.smoothing_alpha > ONE_Q24) ? ONE_Q24 : cfg.smoothing_alpha;
	assign a_comp = ONE_Q24 - a_lim;
	assign k_comp = ONE_Q24 - {1'b0, k_q};

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			ST_MKD: begin
				mul_a = {8'b0, k_q};
				mul_b = {{2{e_q[31]}}, e_q} - {{2{est_q[cmd.axis][31]}}, est_q[cmd.axis]};
			end
			ST_MCOV: begin
				mul_a = {7'b0, k_comp};
				mul_b = {2'b0, p_q};
			end
			ST_MP: begin
				mul_a = {1'b0, cfg.prop_gain};
				mul_b = {{2{e_q[31]}}, e_q};
			end
			ST_MI: begin
				mul_a = {1'b0, cfg.integ_gain};
				mul_b = {{2{integ_q[31]}}, integ_q};
			end
			ST_MD: begin
				mul_a = {1'b0, cfg.deriv_gain};
				mul_b = {deriv_q[32], deriv_q};
			end
			ST_MA: begin
				mul_a = {7'b0, a_lim};
				mul_b = {{2{o_q[31]}}, o_q};
			end
			ST_MNA: begin
				mul_a = {7'b0, a_comp};
				mul_b = {{2{pout_q[cmd.axis][31]}}, pout_q[cmd.axis]};
			end
			default: begin
				mul_a = 32'b0;
				mul_b = 34'sb0;
			end
		endcase
	end
	assign mul_full = $signed({1'b0, mul_a}) * mul_b;

	// estimate, deadband, integral, low-pass and angle arithmetic
	assign est_sum  = (prod_q >>> 24) + 66'(est_q[cmd.axis]);
	assign e33      = {e_q[31], e_q};
	assign mag      = e_q[31] ? -e33 : e33;
	assign sts.dead_hit = mag < $signed({2'b0, cfg.dead_zone});
	assign isum_new = clamp34({{2{isum_q[cmd.axis][31]}}, isum_q[cmd.axis]}
		+ {{2{e_q[31]}}, e_q}, -INTEG_LIM, INTEG_LIM);
	assign lp_f     = sat32(acc_q >>> 24);
	assign pan_new  = clamp34($signed({10'b0, pan_q}) + {{2{delta_q[31]}}, delta_q},
		PAN_MIN, PAN_MAX);
	assign tilt_new = clamp34($signed({11'b0, tilt_q}) - {{2{delta_q[31]}}, delta_q},
		TILT_MIN, TILT_MAX);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tx_q <= target_x;
			ty_q <= target_y;
		end
		case (cmd.op)
			ST_LOAD: begin
				e_q <= e_load;
				p_q <= p_new;
			end
			ST_DIVI: begin
				den_q <= {1'b0, p_q} + {2'b0, r_eff};
				rem_q <= {1'b0, p_q};
				k_q   <= 24'd0;
			end
			ST_DIVS: begin
				rem_q <= div_ge ? 33'(rem2 - {1'b0, den_q}) : rem2[32:0];
				k_q   <= {k_q[22:0], div_ge};
			end
			ST_EST: e_q <= sat32(est_sum);
			ST_DEAD: begin
				if (sts.dead_hit) begin
					delta_q <= 32'sd0;
				end else begin
					integ_q <= isum_new[31:0];
					deriv_q <= e33 - {perr_q[cmd.axis][31], perr_q[cmd.axis]};
				end
			end
			ST_MI:   acc_q <= prod_q;
			ST_MD:   acc_q <= acc_q + prod_q;
			ST_ACC1: acc_q <= acc_q + prod_q;
			ST_CLO:  o_q <= sat32(acc_q >>> 24);
			ST_MNA:  acc_q <= prod_q;
			ST_ACC2: acc_q <= acc_q + prod_q;
			ST_LPU:  delta_q <= lp_f;
			default: ;
		endcase
		prod_q <= mul_full[65:0];
	end

	// per-axis state and angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q  <= PAN_RESET;
			tilt_q <= TILT_RESET;
			for (int i = 0; i < 2; i++) begin
				est_q[i]  <= 32'sd0;
				cov_q[i]  <= COV_RESET;
				isum_q[i] <= 32'sd0;
				perr_q[i] <= 32'sd0;
				pout_q[i] <= 32'sd0;
			end
		end else begin
			case (cmd.op)
				ST_EST: est_q[cmd.axis] <= sat32(est_sum);
				ST_COV: cov_q[cmd.axis] <= prod_q[55:24];
				ST_DEAD: begin
					if (sts.dead_hit) begin
						isum_q[cmd.axis] <= 32'sd0;
						perr_q[cmd.axis] <= 32'sd0;
						pout_q[cmd.axis] <= 32'sd0;
					end else begin
						isum_q[cmd.axis] <= isum_new[31:0];
						perr_q[cmd.axis] <= e_q;
					end
				end
				ST_LPU: pout_q[cmd.axis] <= lp_f;
				ST_ANG: begin
					if (cmd.axis)
						tilt_q <= tilt_new[22:0];
					else
						pan_q <= pan_new[23:0];
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pan_q  <= pan_q;
			out_tilt_q <= tilt_q;
		end
	end
endmodule
`default_nettype wire

// ----- src/two_axis_pid_tracker_core.sv -----
// Pan/tilt tracker: target pixel position in, servo angles in degrees out.
// Input stream s_axis carries one target (x, y) per transfer; the output
// stream m_axis carries one (pan, tilt) pair in unsigned q16.16 per input.
// Gains and filter settings sit on the apb port; the user must write them
// only while idle, which the block itself does not enforce. An item is
// taken only when the sequencer is idle. Per axis the shared multiplier
// runs 12 steps, plus 29 more with the kalman stage enabled (24 of them
// are the bit-serial gain divider); a deadband hit skips the pid steps.
// The next target is taken once the result sits in the output register
// and the sequencer is back at idle.
// The result waits in an output register; a stalled receiver holds the
// sequencer at its last step once a second result is ready.
// Reset puts pan at 90 and tilt at 80 degrees, clears integral, history
// and kalman estimate, sets covariance to one and loads default gains.
// Depends on tpt_pkg, tpt_regs, tpt_ctrl and tpt_dp.
`default_nettype none
module two_axis_pid_tracker_core import tpt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // target_x [9:0], target_y [19:10]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [47:0] m_axis_tdata,   // pan_angle [23:0], tilt_angle [46:24]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	cfg_t        cfg;
	cmd_t        cmd;
	sts_t        sts;
	logic [23:0] pan_angle;
	logic [22:0] tilt_angle;

	assign pready       = 1'b1;
	assign m_axis_tdata = {1'b0, tilt_angle, pan_angle};

	tpt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.kalman_en (cfg.kalman_enable),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.target_x   (s_axis_tdata[9:0]),
		.target_y   (s_axis_tdata[19:10]),
		.sts        (sts),
		.pan_angle  (pan_angle),
		.tilt_angle (tilt_angle)
	);
endmodule
`default_nettype wire

// ----- src/tpt_checker.sv -----
// port-level checks of the pan/tilt tracker, bound to the top level
// depends on two_axis_pid_tracker_core_macros.svh
`default_nettype none
`include "two_axis_pid_tracker_core_macros.svh"
module tpt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);
	// a held result stays offered
	`TPT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
	// one item at a time in the sequencer
	`TPT_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken")
	// pan within its limits
	`TPT_ASSERT_SAME(a_pan_rng, m_axis_tvalid, (m_axis_tdata[23:0] >= 24'd1310720) && (m_axis_tdata[23:0] <= 24'd10485760), "pan out of range")
	// tilt within its limits
	`TPT_ASSERT_SAME(a_tilt_rng, m_axis_tvalid, (m_axis_tdata[46:24] >= 23'd2621440) && (m_axis_tdata[46:24] <= 23'd6553600), "tilt out of range")
endmodule

bind two_axis_pid_tracker_core tpt_checker u_tpt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- dv/two_axis_pid_tracker_checker.sv -----
`timescale 1ns / 1ps
// checker for the pan/tilt tracker: follows register writes, predicts the angles
// of every accepted target and compares them with the output stream; needs tpt_pkg
module two_axis_pid_tracker_checker import tpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // target_x [9:0], target_y [19:10]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,   // pan_angle [23:0], tilt_angle [46:24]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending
);

	localparam longint UNIT = 64'sd16777216;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [22:0] tilt;
		logic [23:0] pan;
	} angles_t;

	angles_t angle_q[$];
	cfg_t    cfg;
	longint  pan_pos, tilt_pos;
	longint  integ_acc[2], last_err[2], last_out[2], est[2];
	longint unsigned cov[2];

	function automatic longint clampl(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// scalar kalman update of one axis, returns the filtered error
	function automatic longint kf_update(input int ax, input longint meas);
		longint unsigned q, r, p, k;
		longint nxt;
		q = cfg.process_noise == 0 ? 64'd1 : 64'(cfg.process_noise);
		r = cfg.measure_noise == 0 ? 64'd1 : 64'(cfg.measure_noise);
		p = cov[ax] + q;
		if (p > 64'hFFFF_FFFF)
			p = 64'hFFFF_FFFF;
		k = (p << 24) / (p + r);
		nxt = est[ax] + ((longint'(k) * (meas - est[ax])) >>> 24);
		nxt = clampl(nxt, S32_MIN, S32_MAX);
		est[ax] = nxt;
		cov[ax] = ((64'(UNIT) - k) * p) >> 24;
		return nxt;
	endfunction

	// one axis: error, optional filter, deadband, pid, low-pass
	function automatic longint axis_track(input int ax, input logic [9:0] tgt);
		longint e, mag, ig, d, raw, o, a, f;
		e = (longint'(tgt) - longint'(CENTRE_PX)) * 65536;
		if (cfg.kalman_enable)
			e = kf_update(ax, e);
		mag = e < 0 ? -e : e;
		if (mag < longint'(cfg.dead_zone)) begin
			integ_acc[ax] = 0;
			last_err[ax] = 0;
			last_out[ax] = 0;
			return 0;
		end
		ig = clampl(integ_acc[ax] + e, -longint'(INTEG_LIM), longint'(INTEG_LIM));
		integ_acc[ax] = ig;
		d = e - last_err[ax];
		last_err[ax] = e;
		raw = longint'(cfg.prop_gain) * e + longint'(cfg.integ_gain) * ig
			+ longint'(cfg.deriv_gain) * d;
		o = clampl(raw >>> 24, S32_MIN, S32_MAX);
		a = longint'(cfg.smoothing_alpha) > UNIT ? UNIT : longint'(cfg.smoothing_alpha);
		f = clampl((a * o + (UNIT - a) * last_out[ax]) >>> 24, S32_MIN, S32_MAX);
		last_out[ax] = f;
		return f;
	endfunction

	function automatic angles_t predict_angles(input logic [9:0] tx, input logic [9:0] ty);
		longint dx, dy;
		angles_t res;
		dx = axis_track(0, tx);
		dy = axis_track(1, ty);
		pan_pos = clampl(pan_pos + dx, longint'(PAN_MIN), longint'(PAN_MAX));
		tilt_pos = clampl(tilt_pos - dy, longint'(TILT_MIN), longint'(TILT_MAX));
		res.pan = pan_pos[23:0];
		res.tilt = tilt_pos[22:0];
		return res;
	endfunction

	// watch register writes, output and input transfers
	always @(posedge clk or negedge arst_n) begin
		angles_t exp_a;
		if (!arst_n) begin
			cfg.prop_gain = 31'd41943;
			cfg.integ_gain = 31'd0;
			cfg.deriv_gain = 31'd50332;
			cfg.dead_zone = 31'd6553600;
			cfg.smoothing_alpha = 25'd8388608;
			cfg.process_noise = 31'd838861;
			cfg.measure_noise = 31'd16777216;
			cfg.kalman_enable = 1'b0;
			pan_pos = longint'(PAN_RESET);
			tilt_pos = longint'(TILT_RESET);
			for (int i = 0; i < 2; i++) begin
				integ_acc[i] = 0;
				last_err[i] = 0;
				last_out[i] = 0;
				est[i] = 0;
				cov[i] = 64'(COV_RESET);
			end
			angle_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_PROP:   cfg.prop_gain = pwdata[30:0];
					REG_INTEG:  cfg.integ_gain = pwdata[30:0];
					REG_DERIV:  cfg.deriv_gain = pwdata[30:0];
					REG_DEAD:   cfg.dead_zone = pwdata[30:0];
					REG_ALPHA:  cfg.smoothing_alpha = pwdata[24:0];
					REG_QNOISE: cfg.process_noise = pwdata[30:0];
					REG_RNOISE: cfg.measure_noise = pwdata[30:0];
					REG_KEN:    cfg.kalman_enable = pwdata[0];
					default: ;
				endcase
			end
			// result transfer against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (angle_q.size() == 0) begin
					$display("%0t: unexpected result pan=%0d tilt=%0d", $time,
						m_axis_tdata[23:0], m_axis_tdata[46:24]);
					errors++;
				end else begin
					exp_a = angle_q.pop_front();
					if (m_axis_tdata[23:0] !== exp_a.pan) begin
						$display("%0t: pan mismatch expected %0d actual %0d", $time,
							exp_a.pan, m_axis_tdata[23:0]);
						errors++;
					end
					if (m_axis_tdata[46:24] !== exp_a.tilt) begin
						$display("%0t: tilt mismatch expected %0d actual %0d", $time,
							exp_a.tilt, m_axis_tdata[46:24]);
						errors++;
					end
				end
			end
			// target transfer
			if (s_axis_tvalid && s_axis_tready)
				angle_q.push_back(predict_angles(s_axis_tdata[9:0], s_axis_tdata[19:10]));
			pending = angle_q.size();
		end
	end

endmodule

// ----- dv/tb_two_axis_pid_tracker_core.sv -----
`timescale 1ns / 1ps
// top of the pan/tilt tracker bench: clock, reset, register phases and target stream
// depends on tpt_pkg, two_axis_pid_tracker_core and two_axis_pid_tracker_checker
module tb_two_axis_pid_tracker_core;
	import tpt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // target_x [9:0], target_y [19:10]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // pan_angle [23:0], tilt_angle [46:24]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          errors, pending;
	int          cycles = 0;
	bit          no_gap_tx = 1'b0;

	always #5 clk = ~clk;

	two_axis_pid_tracker_core dut (.*);

	two_axis_pid_tracker_checker chk (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.errors, .pending
	);

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_two_axis_pid_tracker_core: FAIL");
			$finish;
		end
	end

	// result side: random stalls, none in alternate runs of 150 results, one long hold-off to back up the block
	initial begin
		int n, got;
		got = 0;
		@(posedge arst_n);
		forever begin
			n = (got / 150) % 2 ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got++;
			if (got == 200) begin
				m_axis_tready <= 1'b0;
				repeat (600) @(posedge clk);
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_target(input logic [9:0] tx, input logic [9:0] ty);
		int n;
		n = no_gap_tx ? 0 : $urandom_range(0, 19);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_axis_tdata <= {4'b0, ty, tx};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering, let every result drain and the sequencer settle
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [9:0] rand_px();
		return $urandom_range(0, 2) == 0 ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(240, 400));
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'h7FFF_FFFF;
			default: return $urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	task automatic random_setup;
		reg_write(REG_PROP, rand_gain());
		reg_write(REG_INTEG, $urandom_range(0, 3) == 0 ? rand_gain() : $urandom_range(0, 4096));
		reg_write(REG_DERIV, rand_gain());
		case ($urandom_range(0, 4))
			0: reg_write(REG_DEAD, 32'd0);
			1: reg_write(REG_DEAD, 32'h7FFF_FFFF);
			default: reg_write(REG_DEAD, $urandom_range(0, 60 * 65536));
		endcase
		reg_write(REG_ALPHA, $urandom_range(0, 5) == 0 ? $urandom_range(0, 32'h1FF_FFFF)
			: $urandom_range(0, 32'h100_0000));
		reg_write(REG_QNOISE, $urandom_range(0, 3) == 0 ? 32'd0 : $urandom());
		reg_write(REG_RNOISE, $urandom_range(0, 3) == 0 ? 32'd0 : $urandom());
		reg_write(REG_KEN, $urandom_range(0, 1));
	endtask

	// stimulus phases
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default gains: centre, deadband edges, corners, driving into the angle limits
		send_target(10'd320, 10'd320);
		send_target(10'd420, 10'd220);
		send_target(10'd421, 10'd219);
		send_target(10'd0, 10'd1023);
		send_target(10'd1023, 10'd0);
		repeat (6) send_target(10'd1023, 10'd1023);
		repeat (6) send_target(10'd0, 10'd0);
		send_target(10'd319, 10'd321);
		send_target(10'd682, 10'd341);
		drain();

		// zero noise, full alpha, kalman on, no deadband, heavy integral
		reg_write(REG_PROP, 32'h0010_0000);
		reg_write(REG_INTEG, 32'h0000_4000);
		reg_write(REG_DERIV, 32'h0000_8000);
		reg_write(REG_DEAD, 32'd0);
		reg_write(REG_ALPHA, 32'h0100_0000);
		reg_write(REG_QNOISE, 32'd0);
		reg_write(REG_RNOISE, 32'd0);
		reg_write(REG_KEN, 32'd1);
		repeat (4) send_target(10'd1023, 10'd0);
		repeat (4) send_target(10'd0, 10'd1023);
		for (int i = 0; i < 80; i++) send_target(rand_px(), rand_px());
		drain();

		// alpha above one, covariance saturation, maximum proportional gain
		reg_write(REG_ALPHA, 32'h01FF_FFFF);
		reg_write(REG_QNOISE, 32'h7FFF_FFFF);
		reg_write(REG_RNOISE, 32'h7FFF_FFFF);
		reg_write(REG_PROP, 32'h7FFF_FFFF);
		reg_write(REG_DEAD, 32'd65536);
		for (int i = 0; i < 60; i++) send_target(rand_px(), rand_px());
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			random_setup();
			no_gap_tx = (ph % 3 == 1);
			for (int i = 0; i < 85; i++) send_target(rand_px(), rand_px());
			drain();
		end

		if (errors == 0)
			$display("tb_two_axis_pid_tracker_core: PASS");
		else
			$display("tb_two_axis_pid_tracker_core: FAIL");
		$finish;
	end

endmodule
